[hdl/stt_pkg.sv]
package stt_pkg;

   // Token kind codes.
   localparam logic [5:0] KIND_EOF         = 6'd0;
   localparam logic [5:0] KIND_ERROR       = 6'd1;
   localparam logic [5:0] KIND_IDENT       = 6'd2;
   localparam logic [5:0] KIND_INTEGER     = 6'd3;
   localparam logic [5:0] KIND_FLOAT       = 6'd4;
   localparam logic [5:0] KIND_STRING      = 6'd5;
   localparam logic [5:0] KIND_SINGLE_BASE = 6'd6;
   localparam logic [5:0] KIND_DOUBLE_BASE = 6'd25;
   localparam logic [5:0] KIND_MUT         = 6'd32;
   localparam logic [5:0] KIND_FUNC        = 6'd33;
   localparam logic [5:0] KIND_TRUE        = 6'd34;
   localparam logic [5:0] KIND_FALSE       = 6'd35;
   localparam logic [5:0] KIND_TYPE_NAME   = 6'd36;
   localparam logic [5:0] KIND_FOR         = 6'd37;
   localparam logic [5:0] KIND_FOREACH     = 6'd38;
   localparam logic [5:0] KIND_WHILE       = 6'd39;
   localparam logic [5:0] KIND_IF          = 6'd40;
   localparam logic [5:0] KIND_ELSE        = 6'd41;

   // Characters with a role of their own.
   localparam logic [7:0] CHAR_DOT        = ".";
   localparam logic [7:0] CHAR_UNDERSCORE = "_";
   localparam logic [7:0] CHAR_QUOTE      = "\"";
   localparam logic [7:0] CHAR_NUL        = 8'h00;

   // Keyword table.
   localparam int KW_TABLE   = 15;
   localparam int KW_MAX_LEN = 7;

   localparam logic [2:0] KW_LEN [KW_TABLE] = '{
      3'd3, 3'd4, 3'd4, 3'd5, 3'd6, 3'd3, 3'd5, 3'd4,
      3'd4, 3'd4, 3'd3, 3'd7, 3'd5, 3'd2, 3'd4
   };

   localparam logic [5:0] KW_KIND [KW_TABLE] = '{
      KIND_MUT, KIND_FUNC, KIND_TRUE, KIND_FALSE,
      KIND_TYPE_NAME, KIND_TYPE_NAME, KIND_TYPE_NAME, KIND_TYPE_NAME,
      KIND_TYPE_NAME, KIND_TYPE_NAME,
      KIND_FOR, KIND_FOREACH, KIND_WHILE, KIND_IF, KIND_ELSE
   };

   localparam logic [7:0] KW_CHAR [KW_TABLE][KW_MAX_LEN] = '{
      '{"m", "u", "t", CHAR_NUL, CHAR_NUL, CHAR_NUL, CHAR_NUL},
      '{"f", "u", "n", "c", CHAR_NUL, CHAR_NUL, CHAR_NUL},
      '{"t", "r", "u", "e", CHAR_NUL, CHAR_NUL, CHAR_NUL},
      '{"f", "a", "l", "s", "e", CHAR_NUL, CHAR_NUL},
      '{"s", "t", "r", "i", "n", "g", CHAR_NUL},
      '{"i", "n", "t", CHAR_NUL, CHAR_NUL, CHAR_NUL, CHAR_NUL},
      '{"f", "l", "o", "a", "t", CHAR_NUL, CHAR_NUL},
      '{"b", "o", "o", "l", CHAR_NUL, CHAR_NUL, CHAR_NUL},
      '{"v", "o", "i", "d", CHAR_NUL, CHAR_NUL, CHAR_NUL},
      '{"a", "u", "t", "o", CHAR_NUL, CHAR_NUL, CHAR_NUL},
      '{"f", "o", "r", CHAR_NUL, CHAR_NUL, CHAR_NUL, CHAR_NUL},
      '{"f", "o", "r", "e", "a", "c", "h"},
      '{"w", "h", "i", "l", "e", CHAR_NUL, CHAR_NUL},
      '{"i", "f", CHAR_NUL, CHAR_NUL, CHAR_NUL, CHAR_NUL, CHAR_NUL},
      '{"e", "l", "s", "e", CHAR_NUL, CHAR_NUL, CHAR_NUL}
   };

   // Second character of each double operator, in kind order.
   localparam int DOUBLE_COUNT = 7;
   localparam logic [7:0] DOUBLE_SECOND [DOUBLE_COUNT] = '{
      "=", "=", "=", "&", "|", "*", "/"
   };

   // One token as it leaves the scanner.
   typedef struct packed {
      logic [5:0]  kind;
      logic [15:0] start;
      logic [15:0] length;
   } token_fields_type;

   // Up to two tokens produced by one text word.
   typedef struct packed {
      logic [1:0]       count;
      token_fields_type first;
      token_fields_type second;
   } push_type;

   // Result of an operator table lookup.
   typedef struct packed {
      logic       hit;
      logic [4:0] idx;
   } op_index_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_word(input logic [7:0] c);
      return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) ||
             (c == CHAR_UNDERSCORE);
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
   endfunction

   // Position of a character in the single operator list.
   function automatic op_index_type single_index(input logic [7:0] c);
      op_index_type r;
      r.hit = 1'b1;
      r.idx = 5'd0;
      case (c)
         "=":     r.idx = 5'd0;
         ";":     r.idx = 5'd1;
         "(":     r.idx = 5'd2;
         ")":     r.idx = 5'd3;
         "{":     r.idx = 5'd4;
         "}":     r.idx = 5'd5;
         "[":     r.idx = 5'd6;
         "]":     r.idx = 5'd7;
         "+":     r.idx = 5'd8;
         "-":     r.idx = 5'd9;
         "*":     r.idx = 5'd10;
         "/":     r.idx = 5'd11;
         "%":     r.idx = 5'd12;
         "!":     r.idx = 5'd13;
         ":":     r.idx = 5'd14;
         ".":     r.idx = 5'd15;
         ",":     r.idx = 5'd16;
         ">":     r.idx = 5'd17;
         "<":     r.idx = 5'd18;
         default: r.hit = 1'b0;
      endcase
      return r;
   endfunction

   // Position of a character in the list of double operator first characters.
   function automatic op_index_type double_index(input logic [7:0] c);
      op_index_type r;
      r.hit = 1'b1;
      r.idx = 5'd0;
      case (c)
         ">":     r.idx = 5'd0;
         "<":     r.idx = 5'd1;
         "=":     r.idx = 5'd2;
         "&":     r.idx = 5'd3;
         "|":     r.idx = 5'd4;
         "*":     r.idx = 5'd5;
         "/":     r.idx = 5'd6;
         default: r.hit = 1'b0;
      endcase
      return r;
   endfunction

endpackage

[hdl/stt_scanner.sv]
module stt_scanner #(
   parameter int POSITION_BITS = 16,
   parameter int KEYWORD_COUNT = 15
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  logic              action,
   input  logic [7:0]        text_byte,
   output stt_pkg::push_type push
);
   import stt_pkg::*;

   localparam int PB      = POSITION_BITS;
   localparam int KW_USED = (KEYWORD_COUNT < KW_TABLE) ? KEYWORD_COUNT : KW_TABLE;
   localparam logic [PB-1:0]            POS_MAX  = '1;
   localparam logic [KEYWORD_COUNT-1:0] ALL_CAND = '1;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_NUMBER,
      MODE_WORD,
      MODE_STRING,
      MODE_PENDING
   } mode_type;

   mode_type                 mode_ff, mode_in;
   logic                     dot_seen_ff, dot_seen_in;
   logic [PB-1:0]            position_ff, position_in;
   logic [PB-1:0]            start_ff, start_in;
   logic [PB-1:0]            length_ff, length_in;
   logic [7:0]               pending_ff, pending_in;
   logic [KEYWORD_COUNT-1:0] cand_ff, cand_in;

   function automatic logic [PB-1:0] sat_inc(input logic [PB-1:0] v);
      return (v == POS_MAX) ? v : v + PB'(1);
   endfunction

   function automatic logic [15:0] clip(input logic [PB-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
   endfunction

   // Drops the keywords that do not have this character at this place.
   function automatic logic [KEYWORD_COUNT-1:0] match_cand(
      input logic [KEYWORD_COUNT-1:0] cand,
      input logic [PB-1:0]            len,
      input logic [7:0]               c
   );
      logic [KEYWORD_COUNT-1:0] r;
      r = cand;
      for (int k = 0; k < KW_USED; k++) begin
         if ((len >= PB'(KW_LEN[k])) || (KW_CHAR[k][len[2:0]] != c)) begin
            r[k] = 1'b0;
         end
      end
      return r;
   endfunction

   // Character classes of the incoming byte.
   logic         c_digit, c_word, c_space, c_quote, c_dot;
   op_index_type c_single, c_double, p_double;

   assign c_digit  = is_digit(text_byte);
   assign c_word   = is_word(text_byte);
   assign c_space  = is_space(text_byte);
   assign c_quote  = (text_byte == CHAR_QUOTE);
   assign c_dot    = (text_byte == CHAR_DOT);
   assign c_single = single_index(text_byte);
   assign c_double = double_index(text_byte);
   assign p_double = double_index(pending_ff);

   // Token that closes the open scan, if there is one.
   logic             flush_valid;
   token_fields_type flush_tok;
   logic [5:0]       word_kind;
   op_index_type     p_single;

   assign p_single = single_index(pending_ff);

   always_comb begin
      word_kind = KIND_IDENT;
      for (int k = KW_USED - 1; k >= 0; k--) begin
         if (cand_ff[k] && (length_ff == PB'(KW_LEN[k]))) begin
            word_kind = KW_KIND[k];
         end
      end
      flush_valid      = 1'b1;
      flush_tok.kind   = KIND_EOF;
      flush_tok.start  = clip(start_ff);
      flush_tok.length = clip(length_ff);
      case (mode_ff)
         MODE_NUMBER:  flush_tok.kind = dot_seen_ff ? KIND_FLOAT : KIND_INTEGER;
         MODE_WORD:    flush_tok.kind = word_kind;
         MODE_STRING:  flush_tok.kind = KIND_STRING;
         MODE_PENDING: begin
            flush_tok.kind   = p_single.hit ? KIND_SINGLE_BASE + 6'(p_single.idx)
                                            : KIND_ERROR;
            flush_tok.length = 16'd1;
         end
         default:      flush_valid = 1'b0;
      endcase
   end

   // Scan of a byte that starts from between tokens.
   logic                     idle_emit;
   token_fields_type         idle_tok;
   mode_type                 idle_mode;
   logic [PB-1:0]            idle_start, idle_len;
   logic [7:0]               idle_pend;
   logic [KEYWORD_COUNT-1:0] idle_cand;

   always_comb begin
      idle_emit       = 1'b0;
      idle_tok.kind   = KIND_ERROR;
      idle_tok.start  = clip(position_ff);
      idle_tok.length = 16'd1;
      idle_mode       = MODE_IDLE;
      idle_start      = position_ff;
      idle_len        = '0;
      idle_pend       = '0;
      idle_cand       = ALL_CAND;
      if (c_space) begin
         idle_start = start_ff;
      end else if (c_digit) begin
         idle_mode = MODE_NUMBER;
         idle_len  = PB'(1);
      end else if (c_quote) begin
         idle_mode  = MODE_STRING;
         idle_start = sat_inc(position_ff);
      end else if (c_double.hit) begin
         idle_mode = MODE_PENDING;
         idle_pend = text_byte;
      end else if (c_single.hit) begin
         idle_emit     = 1'b1;
         idle_tok.kind = KIND_SINGLE_BASE + 6'(c_single.idx);
      end else if (c_word) begin
         idle_mode = MODE_WORD;
         idle_len  = PB'(1);
         idle_cand = match_cand(ALL_CAND, '0, text_byte);
      end else begin
         idle_emit = 1'b1;
      end
   end

   // Next state and the tokens of this word.
   logic restart;

   always_comb begin
      mode_in      = mode_ff;
      dot_seen_in  = dot_seen_ff;
      position_in  = position_ff;
      start_in     = start_ff;
      length_in    = length_ff;
      pending_in   = pending_ff;
      cand_in      = cand_ff;
      restart      = 1'b0;
      push.count   = 2'd0;
      push.first   = flush_tok;
      push.second  = idle_tok;
      if (fire) begin
         if (action) begin
            // End of text: flush, then the end-of-file token, then back to reset.
            mode_in     = MODE_IDLE;
            dot_seen_in = 1'b0;
            position_in = '0;
            start_in    = '0;
            length_in   = '0;
            pending_in  = '0;
            cand_in     = ALL_CAND;
            push.second.kind   = KIND_EOF;
            push.second.start  = clip(position_ff);
            push.second.length = 16'd0;
            if (flush_valid) begin
               push.count = 2'd2;
            end else begin
               push.count = 2'd1;
               push.first = push.second;
            end
         end else begin
            position_in = sat_inc(position_ff);
            case (mode_ff)
               MODE_NUMBER: begin
                  if (c_digit || (c_dot && !dot_seen_ff)) begin
                     if (c_dot) begin
                        dot_seen_in = 1'b1;
                     end
                     length_in = sat_inc(length_ff);
                  end else begin
                     restart = 1'b1;
                  end
               end
               MODE_WORD: begin
                  if (c_word) begin
                     cand_in   = match_cand(cand_ff, length_ff, text_byte);
                     length_in = sat_inc(length_ff);
                  end else begin
                     restart = 1'b1;
                  end
               end
               MODE_STRING: begin
                  if (c_quote) begin
                     push.count  = 2'd1;
                     mode_in     = MODE_IDLE;
                     dot_seen_in = 1'b0;
                     length_in   = '0;
                     pending_in  = '0;
                     cand_in     = ALL_CAND;
                  end else begin
                     length_in = sat_inc(length_ff);
                  end
               end
               MODE_PENDING: begin
                  if (p_double.hit && (DOUBLE_SECOND[p_double.idx[2:0]] == text_byte)) begin
                     push.count        = 2'd1;
                     push.first.kind   = KIND_DOUBLE_BASE + 6'(p_double.idx);
                     push.first.length = 16'd2;
                     mode_in           = MODE_IDLE;
                     pending_in        = '0;
                     length_in         = '0;
                  end else begin
                     restart = 1'b1;
                  end
               end
               default: restart = 1'b1;
            endcase
            // The byte ended the open token and is scanned afresh.
            if (restart) begin
               mode_in     = idle_mode;
               dot_seen_in = 1'b0;
               start_in    = idle_start;
               length_in   = idle_len;
               pending_in  = idle_pend;
               cand_in     = idle_cand;
               if (flush_valid) begin
                  push.count = idle_emit ? 2'd2 : 2'd1;
               end else begin
                  push.count = idle_emit ? 2'd1 : 2'd0;
                  push.first = idle_tok;
               end
            end
         end
      end
   end

   // Scanner state.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_IDLE;
         dot_seen_ff <= 1'b0;
         position_ff <= '0;
         start_ff    <= '0;
         length_ff   <= '0;
         pending_ff  <= '0;
         cand_ff     <= ALL_CAND;
      end else begin
         mode_ff     <= mode_in;
         dot_seen_ff <= dot_seen_in;
         position_ff <= position_in;
         start_ff    <= start_in;
         length_ff   <= length_in;
         pending_ff  <= pending_in;
         cand_ff     <= cand_in;
      end
   end

   // The end marker always closes with an end-of-file token as the last one.
   a_eof_last: assert property (@(posedge clock) disable iff (reset)
      fire && action |->
         (push.count == 2'd1 && push.first.kind == KIND_EOF) ||
         (push.count == 2'd2 && push.second.kind == KIND_EOF))
      else $error("end marker without a closing end-of-file token");

   // After the end marker the next text starts at offset zero.
   a_eof_rewind: assert property (@(posedge clock) disable iff (reset)
      fire && action |=> position_ff == '0 && mode_ff == MODE_IDLE)
      else $error("scanner not rewound after end of text");

   // Between tokens no length, pending character or dot flag is left over.
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_IDLE |-> length_ff == '0 && pending_ff == '0 && !dot_seen_ff)
      else $error("stale scan fields while idle");

endmodule

[hdl/stt_queue.sv]
module stt_queue (
   input  logic               clock,
   input  logic               reset,
   input  stt_pkg::push_type  push,
   output logic               room,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [5:0]         rsp_token_kind,
   output logic [15:0]        rsp_token_start,
   output logic [15:0]        rsp_token_length,
   output logic               rsp_last_of_run
);
   import stt_pkg::*;

   localparam int DEPTH = 4;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);

   typedef struct packed {
      token_fields_type tok;
      logic             last;
   } entry_type;

   entry_type        entry_ff [DEPTH];
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             pop;

   // Room for the two tokens that one word can cause.
   assign room      = (count_ff <= CW'(DEPTH - 2));
   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid && rsp_ready;

   assign rsp_token_kind   = entry_ff[rd_ptr_ff].tok.kind;
   assign rsp_token_start  = entry_ff[rd_ptr_ff].tok.start;
   assign rsp_token_length = entry_ff[rd_ptr_ff].tok.length;
   assign rsp_last_of_run  = entry_ff[rd_ptr_ff].last;

   // Pointer and fill bookkeeping.
   always_comb begin
      rd_ptr_in = pop ? rd_ptr_ff + AW'(1) : rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff + AW'(push.count);
      count_in  = count_ff + CW'(push.count) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Token storage; the final token of a run carries the last flag.
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= '{tok: push.first, last: (push.count == 2'd1)};
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ptr_ff + AW'(1)] <= '{tok: push.second, last: 1'b1};
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> (32'(count_ff) + 32'(push.count)) <= DEPTH)
      else $error("token queue overflow");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= DEPTH)
      else $error("token queue count out of range");

   // A waiting token stays put until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_token_kind) &&
         $stable(rsp_token_start) && $stable(rsp_token_length) &&
         $stable(rsp_last_of_run))
      else $error("waiting token changed before it was taken");

endmodule

[hdl/source_text_tokenizer.sv]
// Channel  Direction  Signals                                    Moves
// req      in         req_valid/ready, action, text_byte         one text word per item
// rsp      out        rsp_valid/ready, token kind/start/length,  one token per item
//                     last_of_run
//
// A text word is taken into an input register and scanned once the queue has room;
// its tokens are registered in a four-entry token queue and offered from there.
// One word per cycle is sustained while the queue has room. A word that closes a
// token and is a token of its own, or an end marker that closes one, produces two tokens.
// The scanner takes a word only while the queue has room for two tokens.
// Reset is synchronous and returns the scanner to offset zero between tokens.
// A stalled rsp side fills the queue and then holds req_ready low.
module source_text_tokenizer #(
   parameter int POSITION_BITS = 16,
   parameter int KEYWORD_COUNT = 15
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_action,
   input  logic [7:0]  req_text_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [5:0]  rsp_token_kind,
   output logic [15:0] rsp_token_start,
   output logic [15:0] rsp_token_length,
   output logic        rsp_last_of_run
);
   import stt_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic       in_action_ff;
   logic [7:0] in_byte_ff;
   logic       room;
   logic       fire;
   push_type   push;

   // The held word is scanned when the queue can take its tokens.
   assign fire      = in_valid_ff && room;
   assign req_ready = !in_valid_ff || fire;

   always_comb begin
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_action_ff <= req_action;
         in_byte_ff   <= req_text_byte;
      end
   end

   stt_scanner #(
      .POSITION_BITS (POSITION_BITS),
      .KEYWORD_COUNT (KEYWORD_COUNT)
   ) u_scanner (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .action    (in_action_ff),
      .text_byte (in_byte_ff),
      .push      (push)
   );

   stt_queue u_queue (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .room             (room),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_token_start  (rsp_token_start),
      .rsp_token_length (rsp_token_length),
      .rsp_last_of_run  (rsp_last_of_run)
   );

endmodule

[dv/source_text_tokenizer_tb.sv]
module source_text_tokenizer_tb;
   import stt_pkg::*;

   localparam int CYCLE_LIMIT  = 2_000_000;
   localparam int REPORT_LIMIT = 10;
   localparam int SETTLE_WAIT  = 8;
   localparam int PHASE_WORDS  = 375;

   // Word action codes.
   localparam bit ACT_CHAR = 1'b0;
   localparam bit ACT_END  = 1'b1;

   typedef enum logic [2:0] {
      SCAN_IDLE, SCAN_NUMBER, SCAN_WORD, SCAN_STRING, SCAN_PENDING
   } scan_mode_type;

   typedef struct {
      logic [5:0]  kind;
      logic [15:0] start;
      logic [15:0] length;
      logic        last;
   } token_rec_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_action = 1'b0;
   logic [7:0]  req_text_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [5:0]  rsp_token_kind;
   logic [15:0] rsp_token_start;
   logic [15:0] rsp_token_length;
   logic        rsp_last_of_run;

   source_text_tokenizer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_text_byte    (req_text_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_token_start  (rsp_token_start),
      .rsp_token_length (rsp_token_length),
      .rsp_last_of_run  (rsp_last_of_run)
   );

   // Character tables of the language.
   string      SINGLE_CHARS = "=;(){}[]+-*/%!:.,><";
   string      DOUBLE_FIRST = "><=&|*/";
   string      DOUBLE_NEXT  = "===&|*/";
   bit [7:0]   BLANK_CHARS [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
   string      KEYWORD_WORDS [15] = '{
      "mut", "func", "true", "false", "string", "int", "float", "bool",
      "void", "auto", "for", "foreach", "while", "if", "else"
   };
   logic [5:0] KEYWORD_KINDS [15] = '{
      KIND_MUT, KIND_FUNC, KIND_TRUE, KIND_FALSE,
      KIND_TYPE_NAME, KIND_TYPE_NAME, KIND_TYPE_NAME, KIND_TYPE_NAME,
      KIND_TYPE_NAME, KIND_TYPE_NAME,
      KIND_FOR, KIND_FOREACH, KIND_WHILE, KIND_IF, KIND_ELSE
   };

   // Scanner state kept by the token predictor.
   scan_mode_type scanner_mode;
   bit            dot_seen;
   bit [15:0]     text_pos;
   bit [15:0]     tok_start;
   bit [15:0]     tok_len;
   bit [7:0]      pend_char;
   bit [14:0]     keyword_hits;
   int            emitted_now;

   token_rec_type expected_tokens [$];
   int         failures = 0;
   int         words_sent = 0;
   int         cycle_count = 0;
   int         send_idle_pct = 0;
   int         recv_stall_pct = 0;

   always #5 clock = ~clock;

   // Abort a run that hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("source_text_tokenizer_tb NOT OK");
         $finish;
      end
   end

   // The result side stalls at the rate of the current phase.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic note_failure(input string msg);
      failures++;
      if (failures <= REPORT_LIMIT) $display("mismatch: %s", msg);
   endtask

   function automatic bit [15:0] bump(input bit [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

   function automatic bit char_is_digit(input bit [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic bit char_is_letter(input bit [7:0] c);
      return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) ||
             (c == CHAR_UNDERSCORE);
   endfunction

   function automatic bit char_is_blank(input bit [7:0] c);
      return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
   endfunction

   function automatic int single_slot(input bit [7:0] c);
      int slot;
      slot = -1;
      for (int k = 0; k < SINGLE_CHARS.len(); k++) begin
         if (slot < 0 && SINGLE_CHARS[k] == c) slot = k;
      end
      return slot;
   endfunction

   function automatic int double_slot(input bit [7:0] c);
      int slot;
      slot = -1;
      for (int k = 0; k < DOUBLE_FIRST.len(); k++) begin
         if (slot < 0 && DOUBLE_FIRST[k] == c) slot = k;
      end
      return slot;
   endfunction

   task automatic push_token(input logic [5:0] kind, input bit [15:0] start,
                             input bit [15:0] length);
      token_rec_type tok;
      tok.kind = kind;
      tok.start = start;
      tok.length = length;
      tok.last = 1'b0;
      expected_tokens.push_back(tok);
      emitted_now++;
   endtask

   task automatic reset_scanner();
      scanner_mode = SCAN_IDLE;
      dot_seen = 1'b0;
      text_pos = '0;
      tok_start = '0;
      tok_len = '0;
      pend_char = '0;
      keyword_hits = '1;
   endtask

   // A letter narrows the set of keywords that the word can still become.
   task automatic word_letter(input bit [7:0] c);
      for (int k = 0; k < 15; k++) begin
         if (tok_len >= KEYWORD_WORDS[k].len() || KEYWORD_WORDS[k][tok_len] != c)
            keyword_hits[k] = 1'b0;
      end
      tok_len = bump(tok_len);
   endtask

   // Report the open token, if any, and go back between tokens.
   task automatic close_token();
      logic [5:0] kind;
      int         slot;
      bit         found;
      case (scanner_mode)
         SCAN_NUMBER: begin
            push_token(dot_seen ? KIND_FLOAT : KIND_INTEGER, tok_start, tok_len);
         end
         SCAN_WORD: begin
            kind = KIND_IDENT;
            found = 1'b0;
            for (int k = 0; k < 15; k++) begin
               if (!found && keyword_hits[k] && tok_len == KEYWORD_WORDS[k].len()) begin
                  kind = KEYWORD_KINDS[k];
                  found = 1'b1;
               end
            end
            push_token(kind, tok_start, tok_len);
         end
         SCAN_STRING: begin
            push_token(KIND_STRING, tok_start, tok_len);
         end
         SCAN_PENDING: begin
            slot = single_slot(pend_char);
            push_token(slot >= 0 ? 6'(KIND_SINGLE_BASE + slot) : KIND_ERROR, tok_start, 16'd1);
         end
         default: ;
      endcase
      scanner_mode = SCAN_IDLE;
      dot_seen = 1'b0;
      tok_len = '0;
      pend_char = '0;
      keyword_hits = '1;
   endtask

   // Scan a character that arrives between tokens.
   task automatic scan_from_idle(input bit [7:0] c, input bit [15:0] here);
      int slot;
      if (!char_is_blank(c)) begin
         tok_start = here;
         slot = single_slot(c);
         if (char_is_digit(c)) begin
            scanner_mode = SCAN_NUMBER;
            dot_seen = 1'b0;
            tok_len = 16'd1;
         end else if (c == CHAR_QUOTE) begin
            scanner_mode = SCAN_STRING;
            tok_start = bump(here);
            tok_len = '0;
         end else if (double_slot(c) >= 0) begin
            scanner_mode = SCAN_PENDING;
            pend_char = c;
         end else if (slot >= 0) begin
            push_token(6'(KIND_SINGLE_BASE + slot), here, 16'd1);
         end else if (char_is_letter(c)) begin
            scanner_mode = SCAN_WORD;
            tok_len = '0;
            keyword_hits = '1;
            word_letter(c);
         end else begin
            push_token(KIND_ERROR, here, 16'd1);
         end
      end
   endtask

   // Work out the tokens that one accepted word causes.
   task automatic predict_tokens(input bit act, input bit [7:0] c);
      bit [15:0]     here;
      int            slot;
      token_rec_type tok;
      emitted_now = 0;
      if (act == ACT_END) begin
         close_token();
         push_token(KIND_EOF, text_pos, 16'd0);
         reset_scanner();
      end else begin
         here = text_pos;
         text_pos = bump(text_pos);
         case (scanner_mode)
            SCAN_NUMBER: begin
               if (char_is_digit(c) || (c == CHAR_DOT && !dot_seen)) begin
                  if (c == CHAR_DOT) dot_seen = 1'b1;
                  tok_len = bump(tok_len);
               end else begin
                  close_token();
                  scan_from_idle(c, here);
               end
            end
            SCAN_WORD: begin
               if (char_is_letter(c)) begin
                  word_letter(c);
               end else begin
                  close_token();
                  scan_from_idle(c, here);
               end
            end
            SCAN_STRING: begin
               if (c == CHAR_QUOTE) close_token();
               else tok_len = bump(tok_len);
            end
            SCAN_PENDING: begin
               slot = double_slot(pend_char);
               if (slot >= 0 && DOUBLE_NEXT[slot] == c) begin
                  push_token(6'(KIND_DOUBLE_BASE + slot), tok_start, 16'd2);
                  scanner_mode = SCAN_IDLE;
                  pend_char = '0;
                  tok_len = '0;
               end else begin
                  close_token();
                  scan_from_idle(c, here);
               end
            end
            default: begin
               scan_from_idle(c, here);
            end
         endcase
      end
      if (emitted_now > 0) begin
         tok = expected_tokens.pop_back();
         tok.last = 1'b1;
         expected_tokens.push_back(tok);
      end
   endtask

   // Compare each accepted token with the oldest expected one.
   always @(posedge clock) begin : check_tokens
      token_rec_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (expected_tokens.size() == 0) begin
            note_failure($sformatf("unexpected token kind %0d start %0d length %0d last %0d",
                                   rsp_token_kind, rsp_token_start, rsp_token_length,
                                   rsp_last_of_run));
         end else begin
            want = expected_tokens.pop_front();
            if (want.kind !== rsp_token_kind || want.start !== rsp_token_start ||
                want.length !== rsp_token_length || want.last !== rsp_last_of_run) begin
               note_failure($sformatf(
                  "expected kind %0d start %0d length %0d last %0d, got %0d %0d %0d %0d",
                  want.kind, want.start, want.length, want.last, rsp_token_kind,
                  rsp_token_start, rsp_token_length, rsp_last_of_run));
            end
         end
      end
   end

   // Offer one word and wait until the block takes it.
   task automatic send_word(input bit act, input bit [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_text_byte <= b;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      predict_tokens(act, b);
      words_sent++;
   endtask

   task automatic send_char(input bit [7:0] c);
      send_word(ACT_CHAR, c);
   endtask

   task automatic send_chars(input string s);
      for (int k = 0; k < s.len(); k++) send_char(s[k]);
   endtask

   // Stop sending and let every expected token come out.
   task automatic wait_until_drained();
      req_valid <= 1'b0;
      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   function automatic bit [7:0] random_letter();
      int r;
      r = $urandom_range(52);
      if (r < 26) return 8'("a" + r);
      if (r < 52) return 8'("A" + r - 26);
      return CHAR_UNDERSCORE;
   endfunction

   // One token of random shape, sometimes plain noise.
   task automatic send_random_token();
      string   w;
      int      n;
      int      d;
      bit [7:0] c;
      case ($urandom_range(9))
         0: begin
            w = KEYWORD_WORDS[$urandom_range(14)];
            n = w.len();
            // A cut or lengthened keyword is mostly an identifier.
            case ($urandom_range(3))
               0: n = $urandom_range(1, w.len());
               default: ;
            endcase
            for (int k = 0; k < n; k++) send_char(w[k]);
            if ($urandom_range(5) == 0) send_char(random_letter());
         end
         1, 2: begin
            n = $urandom_range(1, 8);
            for (int k = 0; k < n; k++) send_char(random_letter());
         end
         3: begin
            n = $urandom_range(1, 5);
            d = $urandom_range(0, 2 * n);
            for (int k = 0; k < n; k++) begin
               send_char(8'("0" + $urandom_range(9)));
               if (k == d) send_char(CHAR_DOT);
            end
            if ($urandom_range(5) == 0) send_char(CHAR_DOT);
         end
         4: begin
            send_char(CHAR_QUOTE);
            n = $urandom_range(0, 6);
            for (int k = 0; k < n; k++) begin
               c = 8'($urandom_range(255));
               if (c == CHAR_QUOTE) c = "q";
               send_char(c);
            end
            send_char(CHAR_QUOTE);
         end
         5: begin
            send_char(SINGLE_CHARS[$urandom_range(18)]);
         end
         6: begin
            d = $urandom_range(6);
            send_char(DOUBLE_FIRST[d]);
            send_char(DOUBLE_NEXT[d]);
         end
         7: begin
            send_char(8'($urandom_range(255)));
         end
         default: begin
            n = $urandom_range(1, 3);
            for (int k = 0; k < n; k++) send_char(BLANK_CHARS[$urandom_range(5)]);
         end
      endcase
   endtask

   // A whole text of random tokens closed by the end marker.
   task automatic send_random_text();
      int n;
      n = $urandom_range(2, 20);
      for (int t = 0; t < n; t++) begin
         send_random_token();
         if ($urandom_range(1) == 0) send_char(BLANK_CHARS[$urandom_range(5)]);
      end
      // Now and then the text ends inside a string.
      if ($urandom_range(5) == 0) begin
         send_char(CHAR_QUOTE);
         n = $urandom_range(0, 4);
         for (int k = 0; k < n; k++) send_char(random_letter());
      end
      send_word(ACT_END, 8'($urandom_range(255)));
   endtask

   // Keyword, identifier, operators, float ended by a dot, lone ampersand,
   // bytes that start no token, an unterminated string and an empty text.
   task automatic test_directed_text();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      send_chars("if");
      send_char(8'h09);
      send_chars("x+>=9.5.&");
      send_char(8'h00);
      send_char(8'hFF);
      send_char(8'h20);
      send_char(CHAR_QUOTE);
      send_chars("ab");
      send_word(ACT_END, 8'hFF);
      send_word(ACT_END, 8'h00);
      wait_until_drained();
   endtask

   task automatic test_random_texts(input int send_pct, input int recv_pct);
      int goal;
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      goal = words_sent + PHASE_WORDS;
      while (words_sent < goal) begin
         send_random_text();
         if ($urandom_range(15) == 0) wait_until_drained();
      end
      wait_until_drained();
   endtask

   initial begin
      reset_scanner();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_text();
      test_random_texts(0, 0);
      test_random_texts(50, 0);
      test_random_texts(0, 50);
      test_random_texts(31, 31);

      wait_until_drained();
      repeat (20) @(posedge clock);
      if (expected_tokens.size() != 0)
         note_failure($sformatf("%0d tokens never arrived", expected_tokens.size()));
      if (failures == 0) begin
         $display("source_text_tokenizer_tb OK");
      end else begin
         $display("source_text_tokenizer_tb NOT OK");
      end
      $finish;
   end

endmodule

[sim.f]
hdl/stt_pkg.sv
hdl/stt_scanner.sv
hdl/stt_queue.sv
hdl/source_text_tokenizer.sv
dv/source_text_tokenizer_tb.sv
